### hdl/cba_pkg.sv
// ============================================================================
// cba_pkg
// Shared types and constants for the contiguous block allocator.
// ============================================================================
package cba_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int LEN_W  = 16;
    localparam int BB_W   = 11;
    localparam int BIU_W  = 7;
    localparam int CFG_W  = 11;
    localparam int STEP_W = $clog2(LEN_W);

    // configuration register indexes
    localparam logic CFG_BLOCKS_IN_USE = 1'b0;
    localparam logic CFG_BLOCK_BYTES   = 1'b1;

    localparam logic [BIU_W-1:0] BLOCKS_IN_USE_RST = BIU_W'(64);
    localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = BB_W'(32);

    // request modes
    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_FREE  = 3'd1;
    localparam logic [2:0] MODE_COUNT = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_FILL  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_PASTEND = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_COUNT,
        OP_CLEAR,
        OP_FILL
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_NEED,
        S_SCAN,
        S_APPLY,
        S_COUNT
    } back_state_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [LEN_W-1:0] length_bytes;
        logic [5:0]       start_block;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0]       alloc_start;
        logic [LEN_W-1:0] blocks_needed;
        logic [6:0]       free_blocks;
    } result_t;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] length_bytes;
        logic [5:0]       start_block;
    } qcmd_t;

endpackage

### hdl/cba_front.sv
// ============================================================================
// cba_front
// Accepts requests, decodes the mode and hands them to the queue.
// ============================================================================
module cba_front
    import cba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  cmd_t  cmd,
    output logic  busy,
    input  logic  q_full,
    output logic  push,
    output qcmd_t push_data
);

    logic  stage_valid_reg, stage_valid_next;
    qcmd_t stage_reg;
    logic  accept;
    op_t   op_dec;

    always_comb
    begin
        unique case (cmd.mode)
            MODE_ALLOC: op_dec = OP_ALLOC;
            MODE_FREE:  op_dec = OP_FREE;
            MODE_CLEAR: op_dec = OP_CLEAR;
            MODE_FILL:  op_dec = OP_FILL;
            default:    op_dec = OP_COUNT;   // count and unused modes only report
        endcase
    end

    assign busy   = stage_valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = stage_valid_reg && !q_full;
    assign push_data = stage_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.op           <= op_dec;
            stage_reg.length_bytes <= cmd.length_bytes;
            stage_reg.start_block  <= cmd.start_block;
        end
    end

endmodule

### hdl/cba_queue.sv
// ============================================================================
// cba_queue
// Small FIFO of decoded requests between the front and the back end.
// ============================================================================
module cba_queue
    import cba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qcmd_t push_data,
    output logic  full,
    input  logic  pop,
    output qcmd_t pop_data,
    output logic  empty
);

    qcmd_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/cba_back.sv
// ============================================================================
// cba_back
// Executes requests: serial block-count divide, first-fit scan, map update
// and free-block count; issues one result per request.
// ============================================================================
module cba_back
    import cba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [BIU_W-1:0] blocks_in_use,
    input  logic [BB_W-1:0]  block_bytes,
    input  logic             q_empty,
    input  qcmd_t            q_data,
    output logic             pop,
    output logic             done,
    output result_t          result
);

    back_state_t state_reg, state_next;
    op_t              op_reg, op_next;
    logic [5:0]       start_reg, start_next;
    logic [LEN_W-1:0] dvd_reg, dvd_next;
    logic [LEN_W-1:0] quot_reg, quot_next;
    logic [BB_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [IDX_W-1:0] astart_reg, astart_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [MAX_BLOCKS-1:0] map_reg, map_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic [CNT_W-1:0] n_managed;
    logic [BB_W-1:0]  bsize;
    logic [BB_W:0]    rem_sh;
    logic             rem_ge;
    logic [LEN_W-1:0] need_calc;
    logic [LEN_W:0]   free_end;
    logic             cur_bit;
    logic [CNT_W-1:0] run_inc;
    logic [MAX_BLOCKS-1:0] range_mask;

    assign n_managed = (blocks_in_use > BIU_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                            : CNT_W'(blocks_in_use);
    assign bsize     = (block_bytes == '0) ? BB_W'(1) : block_bytes;

    // restoring divide step
    assign rem_sh    = {rem_reg, dvd_reg[LEN_W-1]};
    assign rem_ge    = (rem_sh >= {1'b0, bsize});
    assign need_calc = quot_reg + LEN_W'(rem_reg != '0);
    assign free_end  = {11'b0, start_reg} + {1'b0, need_reg};

    assign cur_bit = map_reg[idx_reg[IDX_W-1:0]];
    assign run_inc = cur_bit ? '0 : run_reg + 1'b1;

    // per-block range select for the map update
    always_comb
    begin
        for (int j = 0; j < MAX_BLOCKS; j++)
        begin
            unique case (op_reg)
                OP_ALLOC: range_mask[j] = (IDX_W'(j) >= astart_reg)
                                       && (IDX_W'(j) <= idx_reg[IDX_W-1:0]);
                OP_FREE:  range_mask[j] = (IDX_W'(j) >= start_reg)
                                       && ((LEN_W+1)'(j) < free_end)
                                       && (CNT_W'(j) < n_managed);
                default:  range_mask[j] = (CNT_W'(j) < n_managed);
            endcase
        end
    end

    assign pop    = (state_reg == S_IDLE) && !q_empty;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        start_next  = start_reg;
        dvd_next    = dvd_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        need_next   = need_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        astart_next = astart_reg;
        status_next = status_reg;
        free_next   = free_reg;
        map_next    = map_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    op_next     = q_data.op;
                    start_next  = q_data.start_block;
                    dvd_next    = q_data.length_bytes;
                    quot_next   = '0;
                    rem_next    = '0;
                    step_next   = '0;
                    need_next   = '0;
                    astart_next = '0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    free_next   = '0;
                    case (q_data.op)
                        OP_ALLOC, OP_FREE: state_next = S_DIV;
                        OP_CLEAR, OP_FILL: state_next = S_APPLY;
                        default:           state_next = S_COUNT;
                    endcase
                end
            end

            S_DIV:
            begin
                dvd_next  = {dvd_reg[LEN_W-2:0], 1'b0};
                quot_next = {quot_reg[LEN_W-2:0], rem_ge};
                rem_next  = rem_ge ? BB_W'(rem_sh - {1'b0, bsize}) : rem_sh[BB_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LEN_W - 1))
                begin
                    state_next = S_NEED;
                end
            end

            S_NEED:
            begin
                need_next = need_calc;
                idx_next  = '0;
                run_next  = '0;
                if (need_calc == '0)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        status_next = ST_EMPTY;
                    end
                    state_next = S_COUNT;
                end
                else if (op_reg == OP_ALLOC)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    if ({11'b0, start_reg} + {1'b0, need_calc} > (LEN_W+1)'(n_managed))
                    begin
                        status_next = ST_PASTEND;
                    end
                    state_next = S_APPLY;
                end
            end

            S_SCAN:
            begin
                if (idx_reg == n_managed)
                begin
                    status_next = ST_NOSPACE;
                    astart_next = '0;
                    idx_next    = '0;
                    state_next  = S_COUNT;
                end
                else
                begin
                    run_next = run_inc;
                    if (LEN_W'(run_inc) == need_reg)
                    begin
                        // idx_reg now marks the last block of the run
                        astart_next = idx_reg[IDX_W-1:0] + 1'b1 - need_reg[IDX_W-1:0];
                        state_next  = S_APPLY;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_APPLY:
            begin
                case (op_reg)
                    OP_FILL, OP_ALLOC: map_next = map_reg | range_mask;
                    default:           map_next = map_reg & ~range_mask;
                endcase
                idx_next   = '0;
                free_next  = '0;
                state_next = S_COUNT;
            end

            S_COUNT:
            begin
                if (idx_reg == n_managed)
                begin
                    done_next                 = 1'b1;
                    result_next.status        = status_reg;
                    result_next.alloc_start   = 6'(astart_reg);
                    result_next.blocks_needed = need_reg;
                    result_next.free_blocks   = 7'(free_reg);
                    state_next                = S_IDLE;
                end
                else
                begin
                    free_next = free_reg + CNT_W'(!cur_bit);
                    idx_next  = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            map_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        start_reg  <= start_next;
        dvd_reg    <= dvd_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        need_reg   <= need_next;
        idx_reg    <= idx_next;
        run_reg    <= run_next;
        astart_reg <= astart_next;
        status_reg <= status_next;
        free_reg   <= free_next;
        result_reg <= result_next;
    end

endmodule

### hdl/contiguous_block_allocator_top.sv
// ============================================================================
// contiguous_block_allocator_top
// First-fit contiguous block allocator over an occupancy bitmap.
// ============================================================================
// Usage:
//   A request (cmd) is taken on a clock edge with start high and busy low.
//   A decode stage and a two-entry queue hold up to three requests while the
//   engine works; busy rises when both the stage and the queue are full.
//   Each request gives one result: done is high for exactly one cycle with
//   result valid; the receiver cannot stall, results come in request order.
//   Engine work per request (n = managed blocks, at most 64): allocate
//   dispatches, runs the serial divide, works out the blocks needed, scans
//   first-fit block by block, updates the map and counts the free blocks;
//   free does the same without the scan; count only counts; clear and fill
//   update the map and count. Requests run one after another. A request
//   passes the decode stage, the queue, the engine and the done register.
//   The config port (cfg_we, cfg_index, cfg_data) writes blocks_in_use
//   (index 0) or block_bytes (index 1); write only when idle.
//   Reset frees all blocks and loads 64 managed blocks of 32 bytes.
// ============================================================================
module contiguous_block_allocator_top
    import cba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cmd_t             cmd,
    output logic             busy,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [BIU_W-1:0] blocks_in_use_reg;
    logic [BB_W-1:0]  block_bytes_reg;

    logic  q_full, q_empty, push, pop;
    qcmd_t push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
            block_bytes_reg   <= BLOCK_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[BIU_W-1:0];
                CFG_BLOCK_BYTES:   block_bytes_reg   <= cfg_data[BB_W-1:0];
                default:           ;
            endcase
        end
    end

    cba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    cba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    cba_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .blocks_in_use (blocks_in_use_reg),
        .block_bytes   (block_bytes_reg),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .pop           (pop),
        .done          (done),
        .result        (result)
    );

endmodule

### bench/tb_contiguous_block_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator_top
// Self-checking bench for the first-fit contiguous block allocator. A local
// bitmap predictor computes each result when the request is taken. A monitor
// compares every done strobe with the oldest prediction. Directed corner
// requests run first, then random traffic of every mode, mostly alloc/free,
// under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator_top;
    import cba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 160;
    localparam int unsigned PHASE_ITEMS   = 116;
    localparam int unsigned PRINT_CAP     = 40;

    // modes the block leaves undefined
    localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
    localparam logic [2:0] MODE_RSVD_MID   = 3'd6;
    localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } run_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    cmd_t             cmd       = '0;
    logic             busy;
    logic             done;
    result_t          result;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // predictor state
    bit [MAX_BLOCKS-1:0] occupied_blocks = '0;
    logic [BIU_W-1:0]    managed_setting = BLOCKS_IN_USE_RST;
    logic [BB_W-1:0]     block_size      = BLOCK_BYTES_RST;

    cmd_t        pending_requests[$];
    result_t     expected_results[$];
    run_t        live_runs[$];
    result_t     next_expected;
    int unsigned idle_pct        = 0;
    int unsigned error_count     = 0;
    int unsigned requests_taken  = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used   = 1;
    int unsigned alloc_granted   = 0;
    int unsigned alloc_refused   = 0;
    int unsigned cycle_count     = 0;

    contiguous_block_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned managed_count();
        return (managed_setting < MAX_BLOCKS) ? int'(managed_setting) : MAX_BLOCKS;
    endfunction

    function automatic int unsigned effective_block_size();
        return (block_size == '0) ? 1 : int'(block_size);
    endfunction

    // updates the bitmap and returns what the block should report
    function automatic result_t predict_request(cmd_t c);
        result_t     r;
        int unsigned n;
        int unsigned bs;
        int unsigned need;
        int unsigned run;
        int unsigned pos;
        int unsigned i;
        int unsigned nfree;
        bit          found;
        r     = '0;
        n     = managed_count();
        bs    = effective_block_size();
        need  = (int'(c.length_bytes) + bs - 1) / bs;
        run   = 0;
        pos   = 0;
        found = 1'b0;
        case (c.mode)
            MODE_ALLOC:
            begin
                r.blocks_needed = LEN_W'(need);
                if (need == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i < n && !found; i++)
                    begin
                        run = occupied_blocks[i] ? 0 : run + 1;
                        if (run == need)
                        begin
                            found = 1'b1;
                            pos   = i + 1 - need;
                        end
                    end
                    if (found)
                    begin
                        for (i = pos; i < pos + need; i++)
                            occupied_blocks[i] = 1'b1;
                        r.alloc_start = 6'(pos);
                        live_runs.push_back('{pos, need});
                        alloc_granted++;
                    end
                    else
                    begin
                        r.status = ST_NOSPACE;
                        alloc_refused++;
                    end
                end
            end
            MODE_FREE:
            begin
                r.blocks_needed = LEN_W'(need);
                if (need != 0)
                begin
                    for (i = c.start_block; i < n && i - c.start_block < need; i++)
                        occupied_blocks[i] = 1'b0;
                    if (int'(c.start_block) + need > n)
                        r.status = ST_PASTEND;
                end
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < n; i++)
                    occupied_blocks[i] = 1'b0;
                live_runs.delete();
            end
            MODE_FILL:
            begin
                for (i = 0; i < n; i++)
                    occupied_blocks[i] = 1'b1;
            end
            default:
            begin
            end
        endcase
        nfree = 0;
        for (i = 0; i < n; i++)
            if (!occupied_blocks[i])
                nfree++;
        r.free_blocks = 7'(nfree);
        return r;
    endfunction

    // byte length that rounds up to exactly k blocks, clamped to the field
    function automatic logic [LEN_W-1:0] length_for(int unsigned k, int unsigned bs);
        int unsigned hi;
        hi = k * bs;
        if (hi > 65535)
            return 16'hFFFF;
        return LEN_W'($urandom_range(hi - bs + 1, hi));
    endfunction

    function automatic cmd_t make_request();
        cmd_t        c;
        int unsigned n;
        int unsigned bs;
        int unsigned k;
        int unsigned sel;
        int unsigned pick;
        c.mode         = MODE_COUNT;
        c.length_bytes = LEN_W'($urandom);
        c.start_block  = 6'($urandom);
        n   = managed_count();
        bs  = effective_block_size();
        sel = $urandom_range(0, 99);
        if (sel < 42)
        begin
            c.mode = MODE_ALLOC;
            pick   = $urandom_range(0, 9);
            if (n == 0)
                k = $urandom_range(1, 3);
            else if (pick < 7)
                k = $urandom_range(1, (n < 4) ? n : n / 4);
            else if (pick < 9)
                k = $urandom_range(1, n);
            else
                k = $urandom_range(n, n + 2);
            c.length_bytes = length_for(k, bs);
        end
        else if (sel < 75)
        begin
            c.mode = MODE_FREE;
            if (live_runs.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                pick           = $urandom_range(0, live_runs.size() - 1);
                c.start_block  = 6'(live_runs[pick].first);
                c.length_bytes = length_for(live_runs[pick].count, bs);
                live_runs.delete(pick);
            end
            else
            begin
                if (n != 0 && $urandom_range(0, 4) != 0)
                    c.start_block = 6'($urandom_range(0, n - 1));
                c.length_bytes = length_for($urandom_range(1, 4), bs);
            end
        end
        else if (sel < 83)
            c.mode = MODE_COUNT;
        else if (sel < 87)
            c.mode = MODE_CLEAR;
        else if (sel < 90)
            c.mode = MODE_FILL;
        else if (sel < 93)
            c.mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
        else
        begin
            c.mode = $urandom_range(0, 1) ? MODE_FREE : MODE_ALLOC;
            if ($urandom_range(0, 5) == 0)
                c.length_bytes = '0;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("MISMATCH result %0d %s: got %0h expected %0h",
                     results_checked, what, got, want);
    endtask

    task automatic queue_request(input logic [2:0] mode, input logic [LEN_W-1:0] len,
                                 input logic [5:0] blk);
        cmd_t c;
        c.mode         = mode;
        c.length_bytes = len;
        c.start_block  = blk;
        pending_requests.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_results.size() != 0 || start)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCKS_IN_USE)
            managed_setting = val[BIU_W-1:0];
        else
            block_size = val[BB_W-1:0];
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] biu, input logic [CFG_W-1:0] bb,
                             input int unsigned idle);
        int unsigned k;
        wait_drained();
        write_reg(CFG_BLOCKS_IN_USE, biu);
        write_reg(CFG_BLOCK_BYTES, bb);
        settings_used++;
        idle_pct = idle;
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            while (pending_requests.size() >= 2)
                @(posedge clk);
            pending_requests.push_back(make_request());
        end
    endtask

    // request driver: hold start until the transaction is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(predict_request(cmd));
                requests_taken++;
                void'(pending_requests.pop_front());
            end
            if (!start || !busy)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    cmd   <= pending_requests[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("arrived with nothing outstanding, status",
                                16'(result.status), '0);
            else
            begin
                next_expected = expected_results.pop_front();
                if (result.status !== next_expected.status)
                    report_mismatch("status", 16'(result.status),
                                    16'(next_expected.status));
                if (result.alloc_start !== next_expected.alloc_start)
                    report_mismatch("alloc_start", 16'(result.alloc_start),
                                    16'(next_expected.alloc_start));
                if (result.blocks_needed !== next_expected.blocks_needed)
                    report_mismatch("blocks_needed", result.blocks_needed,
                                    next_expected.blocks_needed);
                if (result.free_blocks !== next_expected.free_blocks)
                    report_mismatch("free_blocks", 16'(result.free_blocks),
                                    16'(next_expected.free_blocks));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases on the reset setting: 64 blocks of 32 bytes
        queue_request(MODE_COUNT, 16'd0, 6'd0);
        queue_request(MODE_ALLOC, 16'd0, 6'd0);
        queue_request(MODE_ALLOC, 16'd1, 6'd0);
        queue_request(MODE_ALLOC, 16'hFFFF, 6'h3F);
        queue_request(MODE_ALLOC, 16'd2016, 6'd0);
        queue_request(MODE_ALLOC, 16'd32, 6'd0);
        queue_request(MODE_FREE, 16'd64, 6'd10);
        queue_request(MODE_ALLOC, 16'd33, 6'd0);
        queue_request(MODE_FREE, 16'd96, 6'd63);
        queue_request(MODE_FREE, 16'd0, 6'd5);
        queue_request(MODE_FREE, 16'hFFFF, 6'd0);
        queue_request(MODE_ALLOC, 16'd2048, 6'd0);
        queue_request(MODE_FREE, 16'd2048, 6'd0);
        queue_request(MODE_FILL, 16'd0, 6'd0);
        queue_request(MODE_CLEAR, 16'hFFFF, 6'h3F);
        queue_request(MODE_RSVD_FIRST, 16'hA5A5, 6'h2A);
        queue_request(MODE_RSVD_MID, 16'h5A5A, 6'h15);
        queue_request(MODE_RSVD_LAST, 16'hFFFF, 6'h3F);
        queue_request(MODE_COUNT, 16'hFFFF, 6'h3F);
        wait_drained();

        // no managed blocks, zero block size
        write_reg(CFG_BLOCKS_IN_USE, '0);
        write_reg(CFG_BLOCK_BYTES, '0);
        settings_used++;
        queue_request(MODE_ALLOC, 16'd5, 6'd0);
        queue_request(MODE_FREE, 16'd1, 6'd0);
        queue_request(MODE_FREE, 16'd0, 6'd0);
        queue_request(MODE_FILL, 16'd0, 6'd0);
        queue_request(MODE_COUNT, 16'd0, 6'd0);

        run_phase(11'd64, 11'd32, 0);
        run_phase(11'd16, 11'd1, 82);
        run_phase(11'h7FF, 11'd1024, 0);
        run_phase(11'd1, 11'd7, 16);
        run_phase(11'd2, 11'h7FF, 82);
        run_phase(11'd40, 11'd100, 0);
        run_phase(11'd64, 11'd0, 16);
        run_phase(11'h440, 11'd3, 82);
        wait_drained();

        $display("Ran %0d requests under %0d register settings, %0d results checked.",
                 requests_taken, settings_used, results_checked);
        $display("Allocations granted %0d, refused for lack of room %0d.",
                 alloc_granted, alloc_refused);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hdl/cba_pkg.sv
hdl/cba_front.sv
hdl/cba_queue.sv
hdl/cba_back.sv
hdl/contiguous_block_allocator_top.sv
bench/tb_contiguous_block_allocator_top.sv
